/* hdl/swfp_pkg.sv */
// Shared types and constants for the sync word frame parser.
package swfp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_STATUS,
        PH_RESERVED,
        PH_LENGTH,
        PH_GROUP,
        PH_UNIT,
        PH_PAYLOAD,
        PH_FOOTER
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_FRAME,
        KIND_TIMEOUT,
        KIND_TOO_LONG
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       read_timeout;
    } t_in_item;

    typedef struct packed {
        t_kind              result_kind;
        logic [7:0]         payload_byte;
        logic               last_payload;
        logic signed [15:0] frame_status;
        logic [15:0]        group_id;
        logic [15:0]        unit_id;
        logic [12:0]        frame_length;
    } t_out_item;

    typedef struct packed {
        logic [31:0] hdr_sync;
        logic [31:0] ftr_sync;
    } t_sync_cfg;

    localparam logic [31:0] HDR_SYNC_RESET = 32'hEEEF_FEFF;
    localparam logic [31:0] FTR_SYNC_RESET = 32'hFFFE_EFEE;

endpackage

/* hdl/swfp_cfg_regs.sv */
// APB register file holding the header and footer sync words.
module swfp_cfg_regs
    import swfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_sync_cfg   o_cfg
);

    localparam logic REG_HDR_SYNC = 1'b0;
    localparam logic REG_FTR_SYNC = 1'b1;

    logic [31:0] r_hdr_sync;
    logic [31:0] r_ftr_sync;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_sync <= HDR_SYNC_RESET;
            r_ftr_sync <= FTR_SYNC_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_HDR_SYNC: r_hdr_sync <= pwdata;
                REG_FTR_SYNC: r_ftr_sync <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_HDR_SYNC: prdata = r_hdr_sync;
            REG_FTR_SYNC: prdata = r_ftr_sync;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.hdr_sync = r_hdr_sync;
    assign o_cfg.ftr_sync = r_ftr_sync;

endmodule

/* hdl/swfp_parse_core.sv */
// Frame parsing state machine: sync hunt, field capture and payload count.
module swfp_parse_core
    import swfp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_sync_cfg i_cfg,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam int          LenW   = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [31:0] MaxLen = 32'(MAX_PAYLOAD_BYTES);

    t_phase            r_phase, n_phase;
    logic [1:0]        r_sync_cnt, n_sync_cnt;
    logic [1:0]        r_field_cnt, n_field_cnt;
    logic [31:0]       r_shift;
    logic [15:0]       r_status, r_group, r_unit;
    logic [LenW-1:0]   r_length;
    logic [LenW-1:0]   r_pay_cnt, n_pay_cnt;

    logic [7:0]        rx;
    logic [31:0]       sync_word;
    logic [1:0]        byte_sel;
    logic [7:0]        exp_byte;
    logic [1:0]        hunt_cnt;
    logic              hunt_done;
    logic              field_done;
    logic [31:0]       shift_next;
    logic              too_long;
    logic [LenW-1:0]   pay_inc;
    logic              pay_last;
    logic [31:0]       len_ext;

    assign rx        = i_item.rx_byte;
    assign sync_word = (r_phase == PH_FOOTER) ? i_cfg.ftr_sync : i_cfg.hdr_sync;
    assign byte_sel  = 2'd3 - r_sync_cnt;
    assign exp_byte  = sync_word[{byte_sel, 3'b000} +: 8];

    // Mismatch restarts at one if the byte could open a new sync word.
    always_comb begin
        hunt_done = 1'b0;
        if (rx == exp_byte) begin
            hunt_done = (r_sync_cnt == 2'd3);
            hunt_cnt  = r_sync_cnt + 2'd1;
        end else if (rx == sync_word[31:24]) begin
            hunt_cnt = 2'd1;
        end else begin
            hunt_cnt = 2'd0;
        end
    end

    assign field_done = (r_phase == PH_LENGTH) ? (r_field_cnt == 2'd3)
                                               : (r_field_cnt == 2'd1);
    assign shift_next = {r_shift[23:0], rx};
    assign too_long   = shift_next > MaxLen;
    assign pay_inc    = r_pay_cnt + LenW'(1);
    assign pay_last   = pay_inc >= r_length;
    assign len_ext    = 32'(r_length);

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_sync_cnt  = r_sync_cnt;
        n_field_cnt = r_field_cnt;
        n_pay_cnt   = r_pay_cnt;
        if (i_item.read_timeout) begin
            n_phase     = PH_HEADER;
            n_sync_cnt  = 2'd0;
            n_field_cnt = 2'd0;
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_sync_cnt = hunt_done ? 2'd0 : hunt_cnt;
                    if (hunt_done) begin
                        n_phase     = PH_STATUS;
                        n_field_cnt = 2'd0;
                    end
                end
                PH_STATUS, PH_RESERVED, PH_LENGTH, PH_GROUP, PH_UNIT: begin
                    n_field_cnt = field_done ? 2'd0 : r_field_cnt + 2'd1;
                    if (field_done) begin
                        unique case (r_phase)
                            PH_STATUS:   n_phase = PH_RESERVED;
                            PH_RESERVED: n_phase = PH_LENGTH;
                            PH_LENGTH: begin
                                n_phase = too_long ? PH_HEADER : PH_GROUP;
                                if (too_long) begin
                                    n_sync_cnt = 2'd0;
                                end
                            end
                            PH_GROUP:    n_phase = PH_UNIT;
                            default: begin
                                n_phase    = (r_length != '0) ? PH_PAYLOAD : PH_FOOTER;
                                n_sync_cnt = 2'd0;
                                n_pay_cnt  = '0;
                            end
                        endcase
                    end
                end
                PH_PAYLOAD: begin
                    n_pay_cnt = pay_inc;
                    if (pay_last) begin
                        n_phase    = PH_FOOTER;
                        n_sync_cnt = 2'd0;
                    end
                end
                PH_FOOTER: begin
                    n_sync_cnt = hunt_done ? 2'd0 : hunt_cnt;
                    if (hunt_done) begin
                        n_phase     = PH_HEADER;
                        n_field_cnt = 2'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_res             = '0;
        o_res.result_kind = KIND_PAYLOAD;
        o_res_valid       = 1'b0;
        if (i_item.read_timeout) begin
            o_res_valid       = 1'b1;
            o_res.result_kind = KIND_TIMEOUT;
        end else begin
            case (r_phase)
                PH_LENGTH: begin
                    if (field_done && too_long) begin
                        o_res_valid       = 1'b1;
                        o_res.result_kind = KIND_TOO_LONG;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = rx;
                    o_res.last_payload = pay_last;
                end
                PH_FOOTER: begin
                    if (hunt_done) begin
                        o_res_valid        = 1'b1;
                        o_res.result_kind  = KIND_FRAME;
                        o_res.frame_status = r_status;
                        o_res.group_id     = r_group;
                        o_res.unit_id      = r_unit;
                        o_res.frame_length = len_ext[12:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_sync_cnt  <= 2'd0;
            r_field_cnt <= 2'd0;
            r_pay_cnt   <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_sync_cnt  <= n_sync_cnt;
            r_field_cnt <= n_field_cnt;
            r_pay_cnt   <= n_pay_cnt;
        end
    end

    // Every field is fully shifted in before use, so the data path needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_step && !i_item.read_timeout) begin
            r_shift <= shift_next;
            if (field_done) begin
                case (r_phase)
                    PH_STATUS: r_status <= shift_next[15:0];
                    PH_LENGTH: r_length <= shift_next[LenW-1:0];
                    PH_GROUP:  r_group  <= shift_next[15:0];
                    PH_UNIT:   r_unit   <= shift_next[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* hdl/sync_word_frame_parser.sv */
// Top level of the sync word frame parser.
// Takes one received byte or timeout event per cycle while not stalled and
// gives at most one result per item: a payload byte, a frame-complete report,
// or an error. Items pass from the input register through the parse logic
// into the result register. The input register doubles as a skid stage, so
// a new item is taken while a result waits on a stalled output. The user must
// set the sync words over APB at 0x0 (header) and 0x4 (footer) only while the
// block is idle; the block does not enforce it. No clearing pass after reset.
module sync_word_frame_parser
    import swfp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_sync_cfg cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    logic      accept;
    logic      res_valid;
    t_out_item res;

    swfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    swfp_parse_core #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The held transaction moves on whenever the result slot is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the sync word frame parser: byte stream in, parsed results out.
`timescale 1ns / 100ps

module testbench;
    import swfp_pkg::*;

    localparam int MAX_LEN = 4096;
    localparam logic [2:0] ADDR_HDR_SYNC = 3'd0;
    localparam logic [2:0] ADDR_FTR_SYNC = 3'd4;
    localparam int IDLE_PCT_HEAVY = 76;
    localparam int IDLE_PCT_LIGHT = 20;
    localparam int MAX_GAP = 30;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS_PER_PHASE = 120;
    localparam int MAX_LEN_CUT = 40;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sync_word_frame_parser #(
        .MAX_PAYLOAD_BYTES(MAX_LEN)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_data(i_in_data),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data(o_out_data),
        .i_out_stall(i_out_stall),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // Parser state as the testbench sees it
    logic [31:0] cfg_hdr;
    logic [31:0] cfg_ftr;
    t_phase      parse_phase;
    logic [2:0]  match_cnt;
    logic [1:0]  fld_cnt;
    logic [31:0] fld_shift;
    logic [15:0] held_status;
    logic [15:0] held_group;
    logic [15:0] held_unit;
    logic [12:0] held_len;
    logic [12:0] pay_cnt;

    t_out_item pending_results[$];
    t_out_item expected_head;
    int error_count = 0;
    int items_sent = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;

    function automatic void go_hunt();
        parse_phase = PH_HEADER;
        match_cnt = '0;
        fld_cnt = '0;
        fld_shift = '0;
    endfunction

    function automatic void start_field(t_phase nxt);
        parse_phase = nxt;
        fld_cnt = '0;
        fld_shift = '0;
    endfunction

    function automatic void reset_parser_model();
        cfg_hdr = HDR_SYNC_RESET;
        cfg_ftr = FTR_SYNC_RESET;
        go_hunt();
        held_status = '0;
        held_group = '0;
        held_unit = '0;
        held_len = '0;
        pay_cnt = '0;
    endfunction

    // Returns 1 when the fourth sync byte has just matched
    function automatic bit hunt_sync(logic [31:0] word, logic [7:0] b);
        logic [7:0] want;
        want = word[31 - 8 * match_cnt[1:0] -: 8];
        if (b == want) begin
            match_cnt = match_cnt + 3'd1;
        end else if (b == word[31:24]) begin
            match_cnt = 3'd1;
        end else begin
            match_cnt = 3'd0;
        end
        if (match_cnt >= 3'd4) begin
            match_cnt = 3'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit take_field(logic [7:0] b, int nbytes);
        fld_shift = {fld_shift[23:0], b};
        if (int'(fld_cnt) + 1 >= nbytes) begin
            fld_cnt = '0;
            return 1'b1;
        end
        fld_cnt = fld_cnt + 2'd1;
        return 1'b0;
    endfunction

    function automatic void parse_byte(t_in_item it);
        t_out_item r;
        bit has_result;
        r = '0;
        has_result = 1'b0;
        if (it.read_timeout) begin
            go_hunt();
            r.result_kind = KIND_TIMEOUT;
            has_result = 1'b1;
        end else begin
            case (parse_phase)
                PH_HEADER: begin
                    if (hunt_sync(cfg_hdr, it.rx_byte)) start_field(PH_STATUS);
                end
                PH_STATUS: begin
                    if (take_field(it.rx_byte, 2)) begin
                        held_status = fld_shift[15:0];
                        start_field(PH_RESERVED);
                    end
                end
                PH_RESERVED: begin
                    if (take_field(it.rx_byte, 2)) start_field(PH_LENGTH);
                end
                PH_LENGTH: begin
                    if (take_field(it.rx_byte, 4)) begin
                        if (fld_shift > 32'(MAX_LEN)) begin
                            go_hunt();
                            r.result_kind = KIND_TOO_LONG;
                            has_result = 1'b1;
                        end else begin
                            held_len = fld_shift[12:0];
                            start_field(PH_GROUP);
                        end
                    end
                end
                PH_GROUP: begin
                    if (take_field(it.rx_byte, 2)) begin
                        held_group = fld_shift[15:0];
                        start_field(PH_UNIT);
                    end
                end
                PH_UNIT: begin
                    if (take_field(it.rx_byte, 2)) begin
                        held_unit = fld_shift[15:0];
                        pay_cnt = '0;
                        start_field(held_len != '0 ? PH_PAYLOAD : PH_FOOTER);
                        match_cnt = '0;
                    end
                end
                PH_PAYLOAD: begin
                    pay_cnt = pay_cnt + 13'd1;
                    r.result_kind = KIND_PAYLOAD;
                    r.payload_byte = it.rx_byte;
                    if (pay_cnt >= held_len) begin
                        r.last_payload = 1'b1;
                        parse_phase = PH_FOOTER;
                        match_cnt = '0;
                    end
                    has_result = 1'b1;
                end
                default: begin
                    if (hunt_sync(cfg_ftr, it.rx_byte)) begin
                        r.result_kind = KIND_FRAME;
                        r.frame_status = held_status;
                        r.group_id = held_group;
                        r.unit_id = held_unit;
                        r.frame_length = held_len;
                        go_hunt();
                        has_result = 1'b1;
                    end
                end
            endcase
        end
        if (has_result) pending_results.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Result checking and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual 0x%0h",
                         $time, o_out_data);
                error_count++;
            end else begin
                expected_head = pending_results.pop_front();
                check_field("result_kind", 32'(expected_head.result_kind),
                            32'(o_out_data.result_kind));
                check_field("payload_byte", 32'(expected_head.payload_byte),
                            32'(o_out_data.payload_byte));
                check_field("last_payload", 32'(expected_head.last_payload),
                            32'(o_out_data.last_payload));
                check_field("frame_status", 32'(expected_head.frame_status),
                            32'(o_out_data.frame_status));
                check_field("group_id", 32'(expected_head.group_id),
                            32'(o_out_data.group_id));
                check_field("unit_id", 32'(expected_head.unit_id),
                            32'(o_out_data.unit_id));
                check_field("frame_length", 32'(expected_head.frame_length),
                            32'(o_out_data.frame_length));
            end
        end
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic void set_idling(t_idle_mode mode);
        in_idle_pct = (mode == IDLE_SENDER) ? IDLE_PCT_HEAVY :
                      (mode == IDLE_BOTH) ? IDLE_PCT_LIGHT : 0;
        out_stall_pct = (mode == IDLE_RECEIVER) ? IDLE_PCT_HEAVY :
                        (mode == IDLE_BOTH) ? IDLE_PCT_LIGHT : 0;
    endfunction

    // Valid stays high between back-to-back items; it only drops for a gap
    task automatic send_item(input logic [7:0] b, input bit tmo);
        t_in_item it;
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.rx_byte = b;
        it.read_timeout = tmo;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        parse_byte(it);
        items_sent++;
    endtask

    // cut >= 0 replaces byte number cut with a timeout and ends the frame there.
    // ftr_lead puts partial footer matches ahead of the footer.
    task automatic send_frame(input logic [15:0] status, input logic [31:0] len,
                              input logic [15:0] grp, input logic [15:0] unit,
                              input int cut, input int hdr_skip, input int ftr_lead);
        logic [7:0] fb[$];
        logic [15:0] rsvd;
        rsvd = 16'($urandom());
        for (int i = hdr_skip; i < 4; i++) fb.push_back(cfg_hdr[31 - 8 * i -: 8]);
        fb.push_back(status[15:8]);
        fb.push_back(status[7:0]);
        fb.push_back(rsvd[15:8]);
        fb.push_back(rsvd[7:0]);
        for (int i = 3; i >= 0; i--) fb.push_back(len[8 * i +: 8]);
        if (len <= 32'(MAX_LEN)) begin
            fb.push_back(grp[15:8]);
            fb.push_back(grp[7:0]);
            fb.push_back(unit[15:8]);
            fb.push_back(unit[7:0]);
            for (int i = 0; i < int'(len); i++) fb.push_back(8'($urandom()));
            for (int i = 0; i < ftr_lead; i++) fb.push_back(cfg_ftr[31 - 8 * (i % 2) -: 8]);
            for (int i = 0; i < 4; i++) fb.push_back(cfg_ftr[31 - 8 * i -: 8]);
        end
        for (int i = 0; i < fb.size(); i++) begin
            if (i == cut) begin
                send_item(8'($urandom()), 1'b1);
                return;
            end
            send_item(fb[i], 1'b0);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_sync_reg(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] got;
        apb_xfer(1'b0, addr, '0, got);
        if (got !== want) begin
            $display("%0t: register 0x%0h readback: expected 0x%0h, actual 0x%0h",
                     $time, addr, want, got);
            error_count++;
        end
    endtask

    // Only called with the block idle
    task automatic write_sync_words(input logic [31:0] hdr, input logic [31:0] ftr);
        logic [31:0] unused;
        drain_results();
        apb_xfer(1'b1, ADDR_HDR_SYNC, hdr, unused);
        apb_xfer(1'b1, ADDR_FTR_SYNC, ftr, unused);
        cfg_hdr = hdr;
        cfg_ftr = ftr;
        check_sync_reg(ADDR_HDR_SYNC, hdr);
        check_sync_reg(ADDR_FTR_SYNC, ftr);
    endtask

    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(0, 12);
        if (r < 97) return $urandom_range(13, 64);
        return $urandom_range(65, 300);
    endfunction

    // Mismatch equal to the first sync byte restarts at 1, any other at 0
    task automatic test_sync_restart();
        set_idling(IDLE_NONE);
        send_item(8'hEE, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(8'hEE, 1'b0);
        send_item(8'hEF, 1'b0);
        send_item(8'hEE, 1'b0);
        send_frame(16'h7FFF, 32'd0, 16'h0000, 16'hFFFF, -1, 1, 3);
    endtask

    task automatic test_field_extremes();
        set_idling(IDLE_NONE);
        send_frame(16'h8000, 32'd2, 16'hFFFF, 16'h0000, -1, 0, 0);
        send_frame(16'hFFFF, 32'd1, 16'h0000, 16'hFFFF, -1, 0, 1);
        send_frame(16'h0000, 32'd3, 16'h8001, 16'h7FFE, -1, 0, 0);
    endtask

    // One timeout in every phase; byte offsets follow the frame layout with a 3-byte payload
    task automatic test_timeouts();
        int cuts[9] = '{0, 2, 5, 7, 10, 13, 15, 17, 21};
        set_idling(IDLE_BOTH);
        foreach (cuts[i]) send_frame(16'($urandom()), 32'd3, 16'($urandom()),
                                     16'($urandom()), cuts[i], 0, 0);
    endtask

    task automatic test_length_limit();
        set_idling(IDLE_NONE);
        send_frame(16'h1234, 32'(MAX_LEN + 1), 16'h0, 16'h0, -1, 0, 0);
        send_frame(16'h1234, 32'hFFFF_FFFF, 16'h0, 16'h0, -1, 0, 0);
        send_frame(16'h1234, 32'h0001_0000, 16'h0, 16'h0, -1, 0, 0);
        send_frame(16'h1234, 32'h8000_0000, 16'h0, 16'h0, -1, 0, 0);
    endtask

    task automatic test_config_extremes();
        drain_results();
        check_sync_reg(ADDR_HDR_SYNC, HDR_SYNC_RESET);
        check_sync_reg(ADDR_FTR_SYNC, FTR_SYNC_RESET);
        set_idling(IDLE_BOTH);
        write_sync_words(32'hFFFF_FFFF, 32'h0000_0000);
        send_frame(16'h5A5A, 32'd1, 16'h00FF, 16'hFF00, -1, 0, 0);
        send_frame(16'hA5A5, 32'd0, 16'hFFFF, 16'hFFFF, -1, 0, 2);
        write_sync_words(32'h0000_0000, 32'hFFFF_FFFF);
        send_frame(16'h0F0F, 32'd2, 16'h0000, 16'h0000, -1, 0, 1);
        send_frame(16'hF0F0, 32'd0, 16'h1111, 16'h2222, -1, 0, 0);
    endtask

    // A length at the bound is taken; a timeout ends its payload early
    task automatic test_max_length();
        write_sync_words(HDR_SYNC_RESET, FTR_SYNC_RESET);
        set_idling(IDLE_RECEIVER);
        send_frame(16'($urandom()), 32'(MAX_LEN), 16'($urandom()), 16'($urandom()),
                   MAX_LEN_CUT, 0, 0);
    endtask

    task automatic random_episode();
        int pick;
        int n;
        logic [31:0] len;
        pick = $urandom_range(99);
        if (pick < 60) begin
            if ($urandom_range(3) == 0) begin
                n = $urandom_range(1, 2);
                repeat (n) send_item(8'($urandom()), 1'b0);
            end
            send_frame(16'($urandom()), pick_length(), 16'($urandom()), 16'($urandom()),
                       -1, 0, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
        end else if (pick < 72) begin
            len = pick_length();
            send_frame(16'($urandom()), len, 16'($urandom()), 16'($urandom()),
                       $urandom_range(0, 19 + int'(len)), 0, 0);
        end else if (pick < 80) begin
            len = $urandom_range(1) ? 32'(MAX_LEN + $urandom_range(1, 16))
                                    : ($urandom() | 32'h0000_2000);
            send_frame(16'($urandom()), len, 16'h0, 16'h0, -1, 0, 0);
        end else if (pick < 92) begin
            n = $urandom_range(1, 8);
            repeat (n) send_item(8'($urandom()), $urandom_range(9) == 0);
        end else begin
            // header that breaks off part way
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) send_item(cfg_hdr[31 - 8 * i -: 8], 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        int stop_at;
        logic [31:0] word;
        for (int m = 0; m < 4; m++) begin
            word = $urandom();
            case (m)
                0: write_sync_words(HDR_SYNC_RESET, FTR_SYNC_RESET);
                1: write_sync_words($urandom(), $urandom());
                2: write_sync_words(word, word);
                default: write_sync_words(FTR_SYNC_RESET, HDR_SYNC_RESET);
            endcase
            set_idling(t_idle_mode'(m));
            stop_at = items_sent + RANDOM_ITEMS_PER_PHASE;
            while (items_sent < stop_at) random_episode();
        end
    endtask

    initial begin
        reset_parser_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sync_restart();
        test_field_extremes();
        test_timeouts();
        test_length_limit();
        test_config_extremes();
        test_max_length();
        test_random_traffic();
        drain_results();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
